>>> rtl/rie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rie_pkg
// Shared types, ASCII symbol codes and the microcode ROM of the Roman
// numeral encoder.
// ----------------------------------------------------------------------------
package rie_pkg;

    localparam int VALUE_W  = 12;
    localparam int SYMBOL_W = 7;
    localparam int STEP_W   = 4;

    localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

    localparam logic [SYMBOL_W-1:0] SYM_NONE = 7'h00;
    localparam logic [SYMBOL_W-1:0] SYM_I    = 7'h49;
    localparam logic [SYMBOL_W-1:0] SYM_V    = 7'h56;
    localparam logic [SYMBOL_W-1:0] SYM_X    = 7'h58;
    localparam logic [SYMBOL_W-1:0] SYM_L    = 7'h4C;
    localparam logic [SYMBOL_W-1:0] SYM_C    = 7'h43;
    localparam logic [SYMBOL_W-1:0] SYM_D    = 7'h44;
    localparam logic [SYMBOL_W-1:0] SYM_M    = 7'h4D;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_PAIR,
        SEQ_ERR
    } t_seq_state;

    // One control word: weight to test and subtract, first and second symbol,
    // and whether the step emits a subtractive pair.
    typedef struct packed {
        logic [VALUE_W-1:0]  weight;
        logic [SYMBOL_W-1:0] sym_a;
        logic [SYMBOL_W-1:0] sym_b;
        logic                pair;
    } t_uword;

    // One result item handed from the sequencer to the output register.
    typedef struct packed {
        logic                valid;
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
        logic                out_of_range;
    } t_emit;

    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            4'd0:    w = '{12'd1000, SYM_M, SYM_NONE, 1'b0};
            4'd1:    w = '{12'd900,  SYM_C, SYM_M,    1'b1};
            4'd2:    w = '{12'd500,  SYM_D, SYM_NONE, 1'b0};
            4'd3:    w = '{12'd400,  SYM_C, SYM_D,    1'b1};
            4'd4:    w = '{12'd100,  SYM_C, SYM_NONE, 1'b0};
            4'd5:    w = '{12'd90,   SYM_X, SYM_C,    1'b1};
            4'd6:    w = '{12'd50,   SYM_L, SYM_NONE, 1'b0};
            4'd7:    w = '{12'd40,   SYM_X, SYM_L,    1'b1};
            4'd8:    w = '{12'd10,   SYM_X, SYM_NONE, 1'b0};
            4'd9:    w = '{12'd9,    SYM_I, SYM_X,    1'b1};
            4'd10:   w = '{12'd5,    SYM_V, SYM_NONE, 1'b0};
            4'd11:   w = '{12'd4,    SYM_I, SYM_V,    1'b1};
            default: w = '{12'd1,    SYM_I, SYM_NONE, 1'b0};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/integer_to_roman_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_roman_encoder
// Converts one 12-bit unsigned value into its Roman numeral, sent as a run
// of ASCII symbols, most significant first, with tlast on the final one.
// ----------------------------------------------------------------------------
//  channel   dir   tdata bits              tuser           tlast
//  s_axis    in    [11:0] value            -               -
//  m_axis    out   [6:0]  symbol           out_of_range    last
//
//  A value is taken while the sequencer is idle. The sequencer emits one
//  symbol per cycle while the output is not stalled, and steps past each
//  weight of the 13-step microcode table that the remainder does not cover
//  (3888: 15 symbols). A value of 0 emits nothing; a value above 3999 gives
//  one out-of-range item. Reset is synchronous, active low, and empties the
//  sequencer and the output register. Output stalls hold back the sequencer.
// ----------------------------------------------------------------------------
module integer_to_roman_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] value, [15:12] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] symbol, [7] zero
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] out_of_range
);

    logic                              w_idle;
    logic                              w_load;
    logic                              w_slot_free;
    rie_pkg::t_emit                    w_emit;

    logic                              r_out_vld;
    logic [rie_pkg::SYMBOL_W-1:0]      r_out_sym;
    logic                              r_out_last;
    logic                              r_out_oor;

    // Take a new value only when the previous one is fully sequenced.
    assign s_axis_tready = w_idle;
    assign w_load        = s_axis_tvalid && w_idle;

    // The output register may refill when empty or draining this cycle.
    assign w_slot_free   = !r_out_vld || m_axis_tready;

    rie_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_value     (s_axis_tdata[rie_pkg::VALUE_W-1:0]),
        .i_slot_free (w_slot_free),
        .o_idle      (w_idle),
        .o_emit      (w_emit)
    );

    // Output register: hold while stalled, advance when a symbol is emitted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_slot_free) begin
            r_out_vld <= w_emit.valid;
        end
        if (w_emit.valid) begin
            r_out_sym  <= w_emit.symbol;
            r_out_last <= w_emit.last;
            r_out_oor  <= w_emit.out_of_range;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out_sym};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_oor;

`ifndef SYNTH
    // An error item is a lone, terminated item with no symbol.
    a_err_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == 8'd0)))
        else $error("out-of-range item without last or with a symbol");

    // A regular item always carries a Roman symbol.
    a_sym_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[6:0] != 7'd0))
        else $error("symbol item carries a zero code");

    // A nonzero value keeps the sequencer busy in the following cycle.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tdata[11:0] != 12'd0))
            |=> !s_axis_tready)
        else $error("sequencer idle right after a nonzero value");
`endif

endmodule

>>> rtl/rie_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rie_seq
// Microcoded sequencer: walks the weight table, subtracting and emitting one
// symbol per cycle while the remainder covers the weight and the slot is free.
// ----------------------------------------------------------------------------
module rie_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  logic [rie_pkg::VALUE_W-1:0]     i_value,
    input  logic                            i_slot_free,
    output logic                            o_idle,
    output rie_pkg::t_emit                  o_emit
);

    rie_pkg::t_seq_state              r_state, n_state;
    logic [rie_pkg::STEP_W-1:0]       r_step,  n_step;
    logic [rie_pkg::VALUE_W-1:0]      r_rem,   n_rem;

    rie_pkg::t_uword                  w_uw;
    logic                             w_hit;
    logic [rie_pkg::VALUE_W-1:0]      w_diff;

    assign w_uw   = rie_pkg::ucode(r_step);
    assign w_hit  = (r_rem >= w_uw.weight);
    assign w_diff = r_rem - w_uw.weight;
    assign o_idle = (r_state == rie_pkg::SEQ_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rie_pkg::SEQ_IDLE: begin
                if (i_load) begin
                    if (i_value == '0) begin
                        n_state = rie_pkg::SEQ_IDLE;
                    end else if (i_value > rie_pkg::MAX_VALUE) begin
                        n_state = rie_pkg::SEQ_ERR;
                    end else begin
                        n_state = rie_pkg::SEQ_RUN;
                    end
                end
            end
            rie_pkg::SEQ_RUN: begin
                if (w_hit && i_slot_free) begin
                    if (w_uw.pair) begin
                        n_state = rie_pkg::SEQ_PAIR;
                    end else if (w_diff == '0) begin
                        n_state = rie_pkg::SEQ_IDLE;
                    end
                end
            end
            rie_pkg::SEQ_PAIR: begin
                if (i_slot_free) begin
                    n_state = (r_rem == '0) ? rie_pkg::SEQ_IDLE : rie_pkg::SEQ_RUN;
                end
            end
            rie_pkg::SEQ_ERR: begin
                if (i_slot_free) begin
                    n_state = rie_pkg::SEQ_IDLE;
                end
            end
            default: n_state = rie_pkg::SEQ_IDLE;
        endcase
    end

    // datapath: remainder and step counter
    always_comb begin
        n_rem  = r_rem;
        n_step = r_step;
        case (r_state)
            rie_pkg::SEQ_IDLE: begin
                if (i_load) begin
                    n_rem  = i_value;
                    n_step = '0;
                end
            end
            rie_pkg::SEQ_RUN: begin
                if (w_hit) begin
                    if (i_slot_free) begin
                        n_rem = w_diff;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            default: begin
                n_rem  = r_rem;
                n_step = r_step;
            end
        endcase
    end

    // emitted item
    always_comb begin
        o_emit = '0;
        case (r_state)
            rie_pkg::SEQ_RUN: begin
                o_emit.valid  = w_hit && i_slot_free;
                o_emit.symbol = w_uw.sym_a;
                o_emit.last   = !w_uw.pair && (w_diff == '0);
            end
            rie_pkg::SEQ_PAIR: begin
                o_emit.valid  = i_slot_free;
                o_emit.symbol = w_uw.sym_b;
                o_emit.last   = (r_rem == '0);
            end
            rie_pkg::SEQ_ERR: begin
                o_emit.valid        = i_slot_free;
                o_emit.symbol       = rie_pkg::SYM_NONE;
                o_emit.last         = 1'b1;
                o_emit.out_of_range = 1'b1;
            end
            default: o_emit = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rie_pkg::SEQ_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
        r_rem <= n_rem;
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the integer to Roman numeral encoder. Values go in
// on the slave stream. Each one is expanded into its expected run of ASCII
// symbols, or into a single out-of-range item, and the master stream is
// checked against that run item by item. Both sides idle in random bursts,
// and the run includes one long output hold-off and two drain pauses.
// ----------------------------------------------------------------------------
module tb;

    typedef logic [rie_pkg::VALUE_W-1:0]  t_value;
    typedef logic [rie_pkg::SYMBOL_W-1:0] t_symbol;

    // One expected output item.
    typedef struct packed {
        t_symbol symbol;
        logic    is_last;
        logic    out_of_range;
    } t_glyph;

    // One value waiting to be offered; drain_first holds it back until every
    // earlier symbol has come out.
    typedef struct {
        t_value value;
        bit     drain_first;
    } t_feed;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [11:0] value, [15:12] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [6:0] symbol, [7] zero
    logic        m_axis_tlast;
    logic        m_axis_tuser;   // [0] out_of_range

    t_feed  value_q[$];          // values not yet offered
    t_glyph numeral_q[$];        // symbols still owed by the block
    int     errors       = 0;
    int     values_taken = 0;
    bit     in_fire      = 1'b0; // slave handshake seen at the last rising edge
    bit     holdoff      = 1'b0; // long receiver stall
    bit     quiet        = 1'b0; // no idling in the closing stretch
    int     send_gap     = 0;
    int     recv_stall   = 0;

    integer_to_roman_encoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor: append the symbols one value turns into.
    // ------------------------------------------------------------------------
    function automatic void predict_numeral(input t_value value);
        t_symbol run [$];
        t_symbol ones [3];
        t_symbol fives [3];
        t_symbol tens [3];
        int      digit [3];
        int      v;
        t_glyph  g;
        int      k;
        ones  = '{rie_pkg::SYM_C, rie_pkg::SYM_X, rie_pkg::SYM_I};
        fives = '{rie_pkg::SYM_D, rie_pkg::SYM_L, rie_pkg::SYM_V};
        tens  = '{rie_pkg::SYM_M, rie_pkg::SYM_C, rie_pkg::SYM_X};
        v     = int'(value);
        // Zero owes nothing at all.
        if (value == '0) begin
            return;
        end
        // Above the top value: one flagged item with no symbol.
        if (value > rie_pkg::MAX_VALUE) begin
            g = '{rie_pkg::SYM_NONE, 1'b1, 1'b1};
            numeral_q.insert(numeral_q.size(), g);
            return;
        end
        digit[0] = (v / 100) % 10;
        digit[1] = (v / 10) % 10;
        digit[2] = v % 10;
        for (k = 0; k < v / 1000; k++) begin
            run.insert(run.size(), rie_pkg::SYM_M);
        end
        for (int p = 0; p < 3; p++) begin
            case (digit[p])
                9: begin
                    run.insert(run.size(), ones[p]);
                    run.insert(run.size(), tens[p]);
                end
                4: begin
                    run.insert(run.size(), ones[p]);
                    run.insert(run.size(), fives[p]);
                end
                default: begin
                    if (digit[p] >= 5) begin
                        run.insert(run.size(), fives[p]);
                    end
                    for (k = 0; k < digit[p] % 5; k++) begin
                        run.insert(run.size(), ones[p]);
                    end
                end
            endcase
        end
        foreach (run[i]) begin
            g = '{run[i], (i == run.size() - 1), 1'b0};
            numeral_q.insert(numeral_q.size(), g);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge. New values are
    // predicted first; any symbol leaving now belongs to an older value, so
    // the queue order stays right either way.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_glyph want;
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fire) begin
            predict_numeral(s_axis_tdata[rie_pkg::VALUE_W-1:0]);
            values_taken++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (numeral_q.size() == 0) begin
                $error("unexpected item: symbol %h last %b out_of_range %b",
                       m_axis_tdata[rie_pkg::SYMBOL_W-1:0], m_axis_tlast, m_axis_tuser);
                errors++;
            end else begin
                want = numeral_q.pop_front();
                if (m_axis_tdata[rie_pkg::SYMBOL_W-1:0] !== want.symbol) begin
                    $error("symbol: expected %h, actual %h",
                           want.symbol, m_axis_tdata[rie_pkg::SYMBOL_W-1:0]);
                    errors++;
                end
                if (m_axis_tlast !== want.is_last) begin
                    $error("last: expected %b, actual %b", want.is_last, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tuser !== want.out_of_range) begin
                    $error("out_of_range: expected %b, actual %b",
                           want.out_of_range, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: change the slave side at the falling edge. Hold an offered
    // value until taken, then either idle for a burst or offer the next one.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic        next_valid;
        logic [15:0] next_data;
        next_valid = s_axis_tvalid;
        next_data  = s_axis_tdata;
        if (i_rst_n) begin
            quiet = (value_q.size() < 15);
            if (in_fire) begin
                next_valid = 1'b0;
                if (!quiet && $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(1, 8);
                end
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (value_q.size() > 0 &&
                             !(value_q[0].drain_first && numeral_q.size() != 0)) begin
                    next_data  = {4'b0000, value_q[0].value};
                    next_valid = 1'b1;
                    value_q.pop_front();
                end
            end
        end
        s_axis_tdata  = next_data;
        s_axis_tvalid = next_valid;
    end

    // Receiver: stall in random bursts, never during the closing stretch,
    // and throughout while the long hold-off is on.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (holdoff) begin
                m_axis_tready = 1'b0;
            end else if (quiet) begin
                m_axis_tready = 1'b1;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                recv_stall = $urandom_range(1, 8) - 1;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Long output hold-off while the sender keeps offering, so the block
    // backs up and drops s_axis_tready.
    initial begin
        while (values_taken < 30) begin
            @(posedge i_clk);
        end
        holdoff = 1'b1;
        repeat (300) @(posedge i_clk);
        holdoff = 1'b0;
    end

    // Give up after a generous fixed time.
    initial begin
        #400000;
        $display("tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run.
    // ------------------------------------------------------------------------
    initial begin
        t_value directed [$];
        t_feed  f;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;

        // Directed part: field extremes, both subtractive forms at every
        // place, zero, the longest run, both sides of the top value, and
        // alternating bit patterns.
        directed = '{12'd1, 12'd0, 12'd4, 12'd5, 12'd9, 12'd10, 12'd40, 12'd49,
                     12'd90, 12'd99, 12'd400, 12'd444, 12'd500, 12'd900,
                     12'd999, 12'd1000, 12'd3888, 12'd3999, 12'd4000,
                     12'd4095, 12'd0, 12'd2730, 12'd1365, 12'd3000, 12'd2048};
        foreach (directed[i]) begin
            f.value       = directed[i];
            f.drain_first = 1'b0;
            value_q.insert(value_q.size(), f);
        end

        // Random part: mostly encodable values, some zeros and overflows.
        // At the start and once in the middle, pause the sender until everything is out.
        for (int n = 0; n < 95; n++) begin
            case ($urandom_range(0, 9))
                0:       f.value = '0;
                1:       f.value = t_value'($urandom_range(4000, 4095));
                2:       f.value = t_value'($urandom_range(1, 50));
                default: f.value = t_value'($urandom_range(1, 3999));
            endcase
            f.drain_first = (n == 0 || n == 48);
            value_q.insert(value_q.size(), f);
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Wait for every value to be taken and every symbol to come out,
        // then allow for a zero still in flight before the final check.
        while (value_q.size() != 0 || s_axis_tvalid) begin
            @(posedge i_clk);
        end
        while (numeral_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);
        if (numeral_q.size() != 0) begin
            $error("%0d expected items never arrived", numeral_q.size());
            errors++;
        end

        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/rie_pkg.sv
rtl/rie_seq.sv
rtl/integer_to_roman_encoder.sv
dv/tb.sv
